FILE: rtl/pss_pkg.sv
// Shared types and constants for the proportional slot slice selector.
package pss_pkg;

  localparam int SHARE_REGS = 8;
  localparam int IDX_W      = 3;
  localparam int SHARE_W    = 8;
  localparam int SF_W       = 14;
  localparam int LEN_W      = 11;
  localparam int DIV_STEPS  = SF_W;
  localparam int CNT_W      = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G_LOAD,
    ST_G_RUN,
    ST_D_LOAD,
    ST_D_RUN,
    ST_D_ACC,
    ST_FIN,
    ST_CHECK,
    ST_M_LOAD,
    ST_M_RUN,
    ST_SCAN
  } pss_state_e;

  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic idx_inc;
    logic g_clr;
    logic gcd_load;
    logic gcd_step;
    logic sum_clr;
    logic div_load_share;
    logic div_load_sf;
    logic div_step;
    logic sum_acc;
    logic fin;
    logic emit;
    logic emit_hit;
  } pss_cmd_t;

  typedef struct packed {
    logic stale;
    logic len_zero;
    logic g_zero;
    logic gcd_done;
    logic div_last;
    logic idx_last;
    logic hit;
  } pss_sts_t;

endpackage

FILE: rtl/proportional_slot_slice_selector.sv
// Top level of the proportional slot slice selector.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------
//  request   | start, subframe_number_i                     | taken when start && !busy
//  result    | done_o, owner_valid_o, owner_slice_o         | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_index_i, cfg_wdata_i           | written when cfg_we_i high
//
// After a request busy stays high for a check, a divider load, 14 steps of the
// bit-serial divider for the modulo, then a scan of up to NUM_SLICES run ends, one
// slice a cycle. The result strobe is registered and rises in the cycle in which busy drops.
// With every share zero only the check runs before the strobe.
// After a share write the first request also runs the recompute: per slice a load and a
// subtractive GCD of up to 255 steps, per slice a share division (a load, 14 divider
// steps, an accumulate) unless every share is zero, then a final state that latches the
// frame length. Reset marks the derived values stale; the receiver cannot stall results.
module proportional_slot_slice_selector
  import pss_pkg::*;
#(
  parameter int NUM_SLICES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request
  input  logic               start,
  output logic               busy,
  input  logic [SF_W-1:0]    subframe_number_i,
  // result
  output logic               done_o,
  output logic               owner_valid_o,
  output logic [IDX_W-1:0]   owner_slice_o,
  // share registers
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [SHARE_W-1:0] cfg_wdata_i
);

  pss_cmd_t cmd;
  pss_sts_t sts;

  // Sequence recompute and lookup
  pss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Hold shares, derive run ends, reduce the subframe and scan for the owner
  pss_dp #(
    .NUM_SLICES (NUM_SLICES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .subframe_number_i (subframe_number_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .done_o            (done_o),
    .owner_valid_o     (owner_valid_o),
    .owner_slice_o     (owner_slice_o)
  );

endmodule

FILE: rtl/pss_ctrl.sv
// Sequencer for recompute and query phases of the slot slice selector.
module pss_ctrl
  import pss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  pss_sts_t sts_i,
  output pss_cmd_t cmd_o
);

  pss_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = sts_i.stale ? ST_G_LOAD : ST_CHECK;
        end
      end
      ST_G_LOAD: state_d = ST_G_RUN;
      ST_G_RUN: begin
        if (sts_i.gcd_done) begin
          state_d = sts_i.idx_last ? ST_D_LOAD : ST_G_LOAD;
        end
      end
      ST_D_LOAD: state_d = sts_i.g_zero ? ST_FIN : ST_D_RUN;
      ST_D_RUN: begin
        if (sts_i.div_last) begin
          state_d = ST_D_ACC;
        end
      end
      ST_D_ACC:  state_d = sts_i.idx_last ? ST_FIN : ST_D_LOAD;
      ST_FIN:    state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.len_zero ? ST_IDLE : ST_M_LOAD;
      ST_M_LOAD: state_d = ST_M_RUN;
      ST_M_RUN: begin
        if (sts_i.div_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          cmd_o.idx_clr = 1'b1;
          cmd_o.g_clr = 1'b1;
        end
      end
      ST_G_LOAD: cmd_o.gcd_load = 1'b1;
      ST_G_RUN: begin
        cmd_o.gcd_step = 1'b1;
        if (sts_i.gcd_done) begin
          cmd_o.idx_inc = !sts_i.idx_last;
          cmd_o.idx_clr = sts_i.idx_last;
          cmd_o.sum_clr = sts_i.idx_last;
        end
      end
      ST_D_LOAD: cmd_o.div_load_share = !sts_i.g_zero;
      ST_D_RUN:  cmd_o.div_step = 1'b1;
      ST_D_ACC: begin
        cmd_o.sum_acc = 1'b1;
        cmd_o.idx_inc = !sts_i.idx_last;
      end
      ST_FIN: cmd_o.fin = 1'b1;
      ST_CHECK: begin
        cmd_o.emit = sts_i.len_zero;
      end
      ST_M_LOAD: begin
        cmd_o.div_load_sf = 1'b1;
        cmd_o.idx_clr = 1'b1;
      end
      ST_M_RUN: cmd_o.div_step = 1'b1;
      ST_SCAN: begin
        cmd_o.emit = sts_i.hit || sts_i.idx_last;
        cmd_o.emit_hit = sts_i.hit;
        cmd_o.idx_inc = !sts_i.hit && !sts_i.idx_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/pss_dp.sv
// Datapath: share registers, GCD unit, shared divider, run ends and scan.
module pss_dp
  import pss_pkg::*;
#(
  parameter int NUM_SLICES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [SHARE_W-1:0] cfg_wdata_i,
  input  logic [SF_W-1:0]    subframe_number_i,
  input  pss_cmd_t           cmd_i,
  output pss_sts_t           sts_o,
  output logic               done_o,
  output logic               owner_valid_o,
  output logic [IDX_W-1:0]   owner_slice_o
);

  logic [SHARE_W-1:0] share_q [SHARE_REGS];
  logic [LEN_W-1:0]   run_end_q [SHARE_REGS];
  logic               stale_q;
  logic [LEN_W-1:0]   frame_len_q;
  logic [IDX_W-1:0]   idx_q;
  logic [SHARE_W-1:0] g_q, a_q;
  logic [LEN_W-1:0]   rem_q, divisor_q, sum_q;
  logic [SF_W-1:0]    quo_q, sf_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q, valid_q;
  logic [IDX_W-1:0]   slice_q;

  logic               gcd_done;
  logic [SHARE_W-1:0] gcd_res;
  logic [LEN_W:0]     rem_sh, rem_sub;
  logic               ge;
  logic [LEN_W-1:0]   sum_next;

  // Share registers and stale flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SHARE_REGS; i++) begin
        share_q[i] <= '0;
      end
      stale_q <= 1'b1;
    end else if (cfg_we_i) begin
      share_q[cfg_index_i] <= cfg_wdata_i;
      stale_q <= 1'b1;
    end else if (cmd_i.fin) begin
      stale_q <= 1'b0;
    end
  end

  assign gcd_done = (a_q == '0) || (g_q == '0) || (a_q == g_q);
  assign gcd_res  = (a_q == '0) ? g_q : a_q;

  // Restoring divider step: one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[SF_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor_q});
  assign rem_sub = rem_sh - {1'b0, divisor_q};
  assign sum_next = sum_q + quo_q[LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      frame_len_q <= '0;
      done_q      <= 1'b0;
      valid_q     <= 1'b0;
      slice_q     <= '0;
      cnt_q       <= '0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.emit) begin
        valid_q <= cmd_i.emit_hit;
        slice_q <= cmd_i.emit_hit ? idx_q : '0;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.fin) begin
        frame_len_q <= sum_q;
      end
      if (cmd_i.div_load_share || cmd_i.div_load_sf) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sf_q <= subframe_number_i;
    end
    if (cmd_i.g_clr) begin
      g_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (gcd_done) begin
        g_q <= gcd_res;
      end else if (g_q > a_q) begin
        g_q <= g_q - a_q;
      end
    end
    if (cmd_i.gcd_load) begin
      a_q <= share_q[idx_q];
    end else if (cmd_i.gcd_step && !gcd_done && (a_q > g_q)) begin
      a_q <= a_q - g_q;
    end
    if (cmd_i.div_load_share) begin
      quo_q     <= {{(SF_W-SHARE_W){1'b0}}, share_q[idx_q]};
      divisor_q <= {{(LEN_W-SHARE_W){1'b0}}, g_q};
      rem_q     <= '0;
    end else if (cmd_i.div_load_sf) begin
      quo_q     <= sf_q;
      divisor_q <= frame_len_q;
      rem_q     <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SF_W-2:0], ge};
      rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_next;
      run_end_q[idx_q] <= sum_next;
    end else if (cmd_i.fin && (g_q == '0)) begin
      sum_q <= '0;
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.stale    = stale_q;
    sts_o.len_zero = (frame_len_q == '0);
    sts_o.g_zero   = (g_q == '0);
    sts_o.gcd_done = gcd_done;
    sts_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
    sts_o.idx_last = (idx_q == IDX_W'(NUM_SLICES - 1));
    sts_o.hit      = (rem_q < run_end_q[idx_q]);
  end

  assign done_o        = done_q;
  assign owner_valid_o = valid_q;
  assign owner_slice_o = slice_q;

endmodule

FILE: tb/proportional_slot_slice_selector_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slice selector: a directed table, then random share phases.
module proportional_slot_slice_selector_test;
  import pss_pkg::*;

  localparam int NUM_SLICES    = 8;
  localparam int LIMIT_CYCLES  = 1_000_000;  // watchdog bound on the whole run
  localparam int DRAIN_CYCLES  = 64;         // idle tail after the final drain
  localparam int PHASES        = 25;
  localparam int PHASE_QUERIES = 30;
  localparam int SF_TOP        = 10239;      // last subframe of a hyperframe
  localparam int IDLE_PERCENT  = 13;

  // One answer of the block: valid flag plus owning slice index.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] slice;
  } owner_t;

  typedef enum logic {ROW_WRITE, ROW_QUERY} row_kind_e;

  // One line of the directed table. Rows with known_owner set carry an
  // answer typed by hand; all others are answered by the predictor.
  typedef struct {
    row_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic [SHARE_W-1:0] share;
    logic [SF_W-1:0]    sf;
    bit                 known_owner;
    owner_t             owner;
  } row_t;

  // Shapes of a random share set.
  typedef enum int {
    MIX_RANDOM, MIX_FACTOR, MIX_SINGLE, MIX_EXTREME, MIX_TINY, MIX_EMPTY
  } mix_e;

  // Every input starts at a known value; reset is held from time zero.
  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               start             = 1'b0;
  logic               busy;
  logic [SF_W-1:0]    subframe_number_i = '0;
  logic               done_o;
  logic               owner_valid_o;
  logic [IDX_W-1:0]   owner_slice_o;
  logic               cfg_we_i          = 1'b0;
  logic [IDX_W-1:0]   cfg_index_i       = '0;
  logic [SHARE_W-1:0] cfg_wdata_i       = '0;

  // Predictor state: share registers, slot run ends and frame length.
  logic [SHARE_W-1:0] share_reg [SHARE_REGS];
  logic [LEN_W-1:0]   run_end   [SHARE_REGS];
  logic [LEN_W-1:0]   frame_len;
  bit                 runs_dirty;

  owner_t      owners_due [$];   // answers still owed by the block, oldest first
  row_t        plan [$];         // directed table
  int unsigned cycle_count = 0;
  int unsigned errors      = 0;
  bit          no_idle     = 1'b0;

  proportional_slot_slice_selector #(
    .NUM_SLICES(NUM_SLICES)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .subframe_number_i (subframe_number_i),
    .done_o            (done_o),
    .owner_valid_o     (owner_valid_o),
    .owner_slice_o     (owner_slice_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cycle counter doubles as the watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned gcd_u(int unsigned a, int unsigned b);
    int unsigned t;
    while (a != 0) begin
      t = b % a;
      b = a;
      a = t;
    end
    return b;
  endfunction

  // Reduce the shares by their common divisor and lay the slices out as
  // contiguous runs in register order; absent slices get an empty run.
  function automatic void rebuild_runs();
    int unsigned g     = 0;
    int unsigned total = 0;
    for (int i = 0; i < NUM_SLICES; i++) g = gcd_u(share_reg[i], g);
    for (int i = 0; i < SHARE_REGS; i++) begin
      if (i < NUM_SLICES && g != 0) total += share_reg[i] / g;
      run_end[i] = total[LEN_W-1:0];
    end
    frame_len  = total[LEN_W-1:0];
    runs_dirty = 1'b0;
  endfunction

  // Owner of one subframe: reduce modulo the frame, then find the first run
  // whose end lies past the slot. An empty frame means no allocation.
  function automatic owner_t predict_owner(logic [SF_W-1:0] sf);
    owner_t      o;
    int unsigned slot;
    o = '0;
    if (runs_dirty) rebuild_runs();
    if (frame_len == 0) return o;
    slot = sf % frame_len;
    for (int i = 0; i < NUM_SLICES; i++) begin
      if (slot < run_end[i]) begin
        o.valid = 1'b1;
        o.slice = IDX_W'(i);
        return o;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    errors++;
  endtask

  // Check each result strobe against the oldest owed answer.
  always @(posedge clk_i) begin
    owner_t want;
    if (rst_ni && done_o) begin
      if (owners_due.size() == 0) begin
        report_mismatch("result strobe with no request pending", 0, 1);
      end else begin
        want = owners_due.pop_front();
        if (owner_valid_o !== want.valid)
          report_mismatch("owner_valid", want.valid, owner_valid_o);
        if (owner_slice_o !== want.slice)
          report_mismatch("owner_slice", want.slice, owner_slice_o);
      end
    end
  end

  // Random sender gap; long enough at times to land after the block goes idle.
  task automatic hold_off();
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
    end
  endtask

  // Present one request and hold it until taken. Start stays high on return
  // so back-to-back requests never drop it within a step.
  task automatic send_query(input logic [SF_W-1:0] sf, input bit known_owner,
                            input owner_t typed_owner);
    owner_t want;
    cfg_we_i <= 1'b0;  // close any write burst
    hold_off();
    start             <= 1'b1;
    subframe_number_i <= sf;
    do @(posedge clk_i); while (busy);
    want = predict_owner(sf);
    if (known_owner) want = typed_owner;
    owners_due = {owners_due, want};
    @(negedge clk_i);
  endtask

  // Write one share register; mirror it into the predictor at the edge.
  task automatic write_share(input logic [IDX_W-1:0] idx, input logic [SHARE_W-1:0] val);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      cfg_we_i <= 1'b0;
      @(negedge clk_i);
    end
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    share_reg[idx] = val;
    runs_dirty     = 1'b1;
    @(negedge clk_i);
  endtask

  // Hold off until every owed answer is back and the block is idle.
  task automatic drain();
    start    <= 1'b0;
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    while (owners_due.size() != 0 || busy) @(negedge clk_i);
  endtask

  function automatic void add_write(int unsigned idx, int unsigned val);
    row_t r;
    r.kind        = ROW_WRITE;
    r.idx         = IDX_W'(idx);
    r.share       = SHARE_W'(val);
    r.sf          = '0;
    r.known_owner = 1'b0;
    r.owner       = '0;
    plan          = {plan, r};
  endfunction

  function automatic void add_query(int unsigned sf, bit known_owner = 1'b0,
                                    bit valid = 1'b0, int unsigned slice = 0);
    row_t r;
    r.kind        = ROW_QUERY;
    r.idx         = '0;
    r.share       = '0;
    r.sf          = SF_W'(sf);
    r.known_owner = known_owner;
    r.owner.valid = valid;
    r.owner.slice = IDX_W'(slice);
    plan          = {plan, r};
  endfunction

  // Random share set for one phase. Most shapes rewrite only part of the
  // registers, so leftovers from the previous phase mix in. The next request
  // or drain closes the write burst.
  task automatic load_phase_shares();
    mix_e               mix;
    int unsigned        factor;
    int unsigned        lone;
    logic [SHARE_W-1:0] val;
    mix    = ($urandom_range(0, 99) < 5) ? MIX_EMPTY : mix_e'($urandom_range(0, 4));
    factor = $urandom_range(2, 31);
    lone   = $urandom_range(0, SHARE_REGS - 1);
    for (int i = 0; i < SHARE_REGS; i++) begin
      case (mix)
        MIX_RANDOM:  val = ($urandom_range(0, 99) < 30) ? '0 : SHARE_W'($urandom_range(1, 255));
        MIX_FACTOR:  val = SHARE_W'(factor * $urandom_range(0, 255 / factor));
        MIX_SINGLE:  val = (i == lone) ? SHARE_W'($urandom_range(1, 255)) : '0;
        MIX_EXTREME: begin
          case ($urandom_range(0, 2))
            0:       val = '0;
            1:       val = SHARE_W'(1);
            default: val = '1;
          endcase
        end
        MIX_TINY:    val = SHARE_W'($urandom_range(0, 4));
        default:     val = '0;
      endcase
      if (mix == MIX_EMPTY || mix == MIX_SINGLE || $urandom_range(0, 3) != 0)
        write_share(IDX_W'(i), val);
    end
  endtask

  // Mostly in-range subframes, with the full 14-bit range and both ends mixed in.
  function automatic logic [SF_W-1:0] pick_subframe();
    int unsigned r = $urandom_range(0, 99);
    if (r < 4)  return SF_W'(SF_TOP);
    if (r < 8)  return '1;
    if (r < 22) return SF_W'($urandom_range(0, (1 << SF_W) - 1));
    return SF_W'($urandom_range(0, SF_TOP));
  endfunction

  initial begin
    for (int i = 0; i < SHARE_REGS; i++) begin
      share_reg[i] = '0;
      run_end[i]   = '0;
    end
    frame_len  = '0;
    runs_dirty = 1'b1;

    // No shares after reset: nothing allocated, even at the top subframe.
    add_query(0, 1'b1, 1'b0, 0);
    add_query(16383, 1'b1, 1'b0, 0);
    // Lone full share: slice 0 owns every slot.
    add_write(0, 255);
    add_query(0, 1'b1, 1'b1, 0);
    add_query(16383, 1'b1, 1'b1, 0);
    // Equal shares on 0 and 3; slices 1 and 2 are absent but not renumbered.
    add_write(3, 255);
    add_query(0, 1'b1, 1'b1, 0);
    add_query(1, 1'b1, 1'b1, 3);
    add_query(SF_TOP, 1'b1, 1'b1, 3);
    // Coprime share on the last slice: frame of 511 slots.
    add_write(7, 1);
    add_query(255);
    add_query(510);
    add_query(16383);
    // All eight equal: one slot each.
    add_write(1, 255);
    add_write(2, 255);
    add_write(4, 255);
    add_write(5, 255);
    add_write(6, 255);
    add_write(7, 255);
    add_query(5, 1'b1, 1'b1, 5);
    add_query(7, 1'b1, 1'b1, 7);
    add_query(8200, 1'b1, 1'b1, 0);
    // Drop a middle slice.
    add_write(3, 0);
    add_query(3);
    // Back to all zero after having been configured.
    for (int i = 0; i < SHARE_REGS; i++) add_write(i, 0);
    add_query(12345, 1'b1, 1'b0, 0);
    // Common divisor of three: runs of two and three slots.
    add_write(2, 6);
    add_write(5, 9);
    add_query(4);
    add_query(1);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table; drain before each burst of writes.
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        if (k == 0 || plan[k-1].kind == ROW_QUERY) drain();
        write_share(plan[k].idx, plan[k].share);
      end else begin
        send_query(plan[k].sf, plan[k].known_owner, plan[k].owner);
      end
    end

    // Random phases. Phases 8 to 11 run back to back with no gaps, and 9 to 11 make no
    // share changes; elsewhere most phases load a new share set.
    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle = (ph >= 8 && ph < 12);
      if (ph <= 8 || (ph >= 12 && $urandom_range(0, 7) != 0)) begin
        drain();
        load_phase_shares();
      end
      for (int n = 0; n < PHASE_QUERIES; n++) begin
        // Pause until drained: always once in phase 3, otherwise now and then.
        if ((ph == 3 && n == 15) || (!no_idle && $urandom_range(0, 99) < 2)) drain();
        send_query(pick_subframe(), 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
